FILE: rtl/rrts_pkg.sv
// ============================================================================
// rrts_pkg: shared types and codes for the round-robin task scheduler
// Holds request, result-status and run-state codes, the controller state
// type and the command and status bundles between controller and datapath.
// ============================================================================
package rrts_pkg;

    // Request kinds carried in the func field.
    typedef enum logic [2:0] {
        FN_CREATE     = 3'd0,
        FN_SWITCH     = 3'd1,
        FN_SEM_INIT   = 3'd2,
        FN_SEM_WAIT   = 3'd3,
        FN_SEM_SIGNAL = 3'd4
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NO_RUN    = 2'd2,
        ST_NO_WAITER = 2'd3
    } t_status;

    // Per-task run state.
    typedef enum logic [1:0] {
        RUN_CREATED = 2'd0,
        RUN_READY   = 2'd1,
        RUN_RUNNING = 2'd2
    } t_run;

    // Saturation limits of a semaphore count.
    localparam logic signed [15:0] SEM_MIN = 16'sh8000;
    localparam logic signed [15:0] SEM_MAX = 16'sh7fff;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CREATE_WR,
        S_CREATE_LINK,
        S_SWITCH_WR,
        S_WAIT_WR,
        S_SIG_START,
        S_WALK_RD,
        S_WALK_CHK,
        S_SW_DATA,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic sem_wr;
        logic res_full;
        logic ctl_rd_cur;
        logic create_wr;
        logic create_link;
        logic switch_wr;
        logic wait_wr;
        logic walk_init;
        logic ctl_rd_p;
        logic walk_step;
        logic sp_rd_p;
        logic sig_clear;
        logic res_no_run;
        logic res_no_waiter;
        logic switch_fin;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] func;
        logic       table_full;
        logic       sem_ok;
        logic       wait_blocks;
        logic       signal_walks;
        logic       walk_match;
        logic       walk_last;
        logic       out_free;
    } t_dp_sts;

endpackage

FILE: rtl/rrts_ram.sv
// ============================================================================
// rrts_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// its value until the next read enable.
// ============================================================================
module rrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Storage array with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/rrts_ctrl.sv
// ============================================================================
// rrts_ctrl: request sequencer of the task scheduler
// Decodes each accepted request and steps the datapath through table
// reads, writes and the ring walk, then hands the result to the output.
// ============================================================================
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.func)
                    FN_CREATE: begin
                        n_state = i_sts.table_full ? S_DONE : S_CREATE_WR;
                    end
                    FN_SWITCH: begin
                        n_state = S_SWITCH_WR;
                    end
                    FN_SEM_WAIT: begin
                        n_state = (i_sts.sem_ok && i_sts.wait_blocks) ? S_WAIT_WR : S_DONE;
                    end
                    FN_SEM_SIGNAL: begin
                        n_state = (i_sts.sem_ok && i_sts.signal_walks) ? S_SIG_START : S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CREATE_WR:   n_state = S_CREATE_LINK;
            S_CREATE_LINK: n_state = S_DONE;
            S_SWITCH_WR:   n_state = S_WALK_RD;
            S_WAIT_WR:     n_state = S_DONE;
            S_SIG_START:   n_state = S_WALK_RD;
            S_WALK_RD:     n_state = S_WALK_CHK;
            S_WALK_CHK: begin
                if (i_sts.walk_match) begin
                    n_state = (i_sts.func == FN_SWITCH) ? S_SW_DATA : S_DONE;
                end else if (i_sts.walk_last) begin
                    n_state = S_DONE;
                end
            end
            S_SW_DATA: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
            end
            S_DISPATCH: begin
                unique case (i_sts.func)
                    FN_CREATE: begin
                        o_cmd.res_full   = i_sts.table_full;
                        o_cmd.ctl_rd_cur = !i_sts.table_full;
                    end
                    FN_SWITCH: begin
                        o_cmd.ctl_rd_cur = 1'b1;
                    end
                    FN_SEM_INIT: begin
                        o_cmd.sem_wr = i_sts.sem_ok;
                    end
                    FN_SEM_WAIT: begin
                        o_cmd.sem_wr     = i_sts.sem_ok;
                        o_cmd.ctl_rd_cur = i_sts.sem_ok && i_sts.wait_blocks;
                    end
                    FN_SEM_SIGNAL: begin
                        o_cmd.sem_wr     = i_sts.sem_ok;
                        o_cmd.ctl_rd_cur = i_sts.sem_ok && i_sts.signal_walks;
                    end
                    default: begin
                    end
                endcase
            end
            S_CREATE_WR: begin
                o_cmd.create_wr = 1'b1;
            end
            S_CREATE_LINK: begin
                o_cmd.create_link = 1'b1;
            end
            S_SWITCH_WR: begin
                o_cmd.switch_wr = 1'b1;
                o_cmd.walk_init = 1'b1;
            end
            S_WAIT_WR: begin
                o_cmd.wait_wr = 1'b1;
            end
            S_SIG_START: begin
                o_cmd.walk_init = 1'b1;
            end
            S_WALK_RD: begin
                o_cmd.ctl_rd_p = 1'b1;
            end
            S_WALK_CHK: begin
                if (i_sts.walk_match) begin
                    o_cmd.sp_rd_p   = (i_sts.func == FN_SWITCH);
                    o_cmd.sig_clear = (i_sts.func != FN_SWITCH);
                end else if (i_sts.walk_last) begin
                    o_cmd.res_no_run    = (i_sts.func == FN_SWITCH);
                    o_cmd.res_no_waiter = (i_sts.func != FN_SWITCH);
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_SW_DATA: begin
                o_cmd.switch_fin = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/rrts_dpath.sv
// ============================================================================
// rrts_dpath: task table, semaphores and result register of the scheduler
// Keeps the ring links, block tags and run states in one RAM with per-slot
// valid bits, stack pointers and entry addresses in two RAMs, the
// semaphore counts in registers, and drives the output register.
// ============================================================================
module rrts_dpath
    import rrts_pkg::*;
#(
    parameter int TASK_SLOTS = 8,
    parameter int SEM_COUNT  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_func,
    input  logic [31:0]        i_entry_addr,
    input  logic [31:0]        i_stack_base,
    input  logic [15:0]        i_stack_bytes,
    input  logic [31:0]        i_saved_sp,
    input  logic [2:0]         i_sem_index,
    input  logic signed [15:0] i_init_count,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [2:0]         o_task_id,
    output logic [31:0]        o_next_sp,
    output logic               o_start_new,
    output logic [31:0]        o_start_entry,
    output logic               o_switch_request,
    output logic [1:0]         o_status
);

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int USED_W = $clog2(TASK_SLOTS + 1);
    localparam int TAG_W  = $clog2(SEM_COUNT + 1);
    localparam int SEM_W  = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int CTL_W  = 2 + TAG_W + SLOT_W;

    // Latched request fields.
    logic [2:0]         r_func;
    logic [31:0]        r_entry_addr;
    logic [31:0]        r_stack_top;
    logic [31:0]        r_saved_sp;
    logic [2:0]         r_sem_index;
    logic signed [15:0] r_init_count;

    // Scheduler state.
    logic [SLOT_W-1:0]     r_cur;
    logic [USED_W-1:0]     r_used;
    logic [TASK_SLOTS-1:0] r_ctl_v;
    logic                  r_rd_v;
    logic signed [15:0]    r_sem [SEM_COUNT];

    // Ring walk.
    logic [SLOT_W-1:0] r_p;
    logic [SLOT_W-1:0] r_cnt;
    logic [TAG_W-1:0]  r_want;

    // Pending result and output register.
    logic [2:0]  r_res_task_id;
    logic [31:0] r_res_next_sp;
    logic        r_res_start_new;
    logic [31:0] r_res_start_entry;
    logic        r_res_sw_req;
    t_status     r_res_status;
    logic        r_out_valid;
    logic [2:0]  r_out_task_id;
    logic [31:0] r_out_next_sp;
    logic        r_out_start_new;
    logic [31:0] r_out_start_entry;
    logic        r_out_sw_req;
    t_status     r_out_status;

    // RAM ports.
    logic              ctl_wr_en;
    logic [SLOT_W-1:0] ctl_wr_addr;
    logic [CTL_W-1:0]  ctl_wr_data;
    logic              ctl_rd_en;
    logic [SLOT_W-1:0] ctl_rd_addr;
    logic [CTL_W-1:0]  ctl_q;
    logic [CTL_W-1:0]  ctl_eff;
    logic              sp_wr_en;
    logic [SLOT_W-1:0] sp_wr_addr;
    logic [31:0]       sp_wr_data;
    logic [31:0]       sp_q;
    logic [31:0]       entry_q;

    logic [SLOT_W-1:0]  q_next;
    logic [TAG_W-1:0]   q_tag;
    logic [1:0]         q_state;
    logic [SLOT_W-1:0]  new_slot;
    logic [SEM_W-1:0]   sem_idx;
    logic [TAG_W-1:0]   sem_tag;
    logic signed [15:0] sem_cur;
    logic signed [15:0] sem_dec;
    logic signed [15:0] sem_inc;
    logic               sem_ok;
    logic               start_new;
    logic               out_free;

    // Control word fields; a slot never written reads as all zero.
    assign ctl_eff  = r_rd_v ? ctl_q : '0;
    assign q_next   = ctl_eff[SLOT_W-1:0];
    assign q_tag    = ctl_eff[SLOT_W +: TAG_W];
    assign q_state  = ctl_eff[SLOT_W + TAG_W +: 2];
    assign new_slot = r_used[SLOT_W-1:0];

    // Semaphore arithmetic with saturation.
    assign sem_ok  = (32'(r_sem_index) < 32'(SEM_COUNT));
    assign sem_idx = SEM_W'(r_sem_index);
    assign sem_tag = TAG_W'(r_sem_index) + TAG_W'(1);
    assign sem_cur = r_sem[sem_idx];
    assign sem_dec = (sem_cur != SEM_MIN) ? (sem_cur - 16'sd1) : sem_cur;
    assign sem_inc = (sem_cur != SEM_MAX) ? (sem_cur + 16'sd1) : sem_cur;

    assign start_new = (q_state != RUN_READY);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Status toward the controller.
    always_comb begin
        o_sts.func         = r_func;
        o_sts.table_full   = (r_used >= USED_W'(TASK_SLOTS));
        o_sts.sem_ok       = sem_ok;
        o_sts.wait_blocks  = (sem_dec < 16'sd0);
        o_sts.signal_walks = (sem_inc <= 16'sd0);
        o_sts.walk_match   = (q_tag == r_want);
        o_sts.walk_last    = (r_cnt == SLOT_W'(TASK_SLOTS - 1));
        o_sts.out_free     = out_free;
    end

    // Control RAM read port: current slot, walk pointer, or next link.
    always_comb begin
        ctl_rd_en   = i_cmd.ctl_rd_cur || i_cmd.ctl_rd_p || i_cmd.walk_step;
        ctl_rd_addr = r_cur;
        if (i_cmd.ctl_rd_p) begin
            ctl_rd_addr = r_p;
        end else if (i_cmd.walk_step) begin
            ctl_rd_addr = q_next;
        end
    end

    // Control RAM write port.
    always_comb begin
        ctl_wr_en   = 1'b1;
        ctl_wr_addr = r_cur;
        ctl_wr_data = {q_state, q_tag, q_next};
        if (i_cmd.create_wr) begin
            ctl_wr_addr = new_slot;
            ctl_wr_data = {RUN_CREATED, TAG_W'(0), q_next};
        end else if (i_cmd.create_link) begin
            ctl_wr_data = {q_state, q_tag, new_slot};
        end else if (i_cmd.switch_wr) begin
            ctl_wr_data = {RUN_READY, q_tag, q_next};
        end else if (i_cmd.wait_wr) begin
            ctl_wr_data = {q_state, sem_tag, q_next};
        end else if (i_cmd.sig_clear) begin
            ctl_wr_addr = r_p;
            ctl_wr_data = {q_state, TAG_W'(0), q_next};
        end else if (i_cmd.switch_fin) begin
            ctl_wr_addr = r_p;
            ctl_wr_data = {RUN_RUNNING, q_tag, q_next};
        end else begin
            ctl_wr_en = 1'b0;
        end
    end

    // Stack pointer RAM write port: new stack top or saved pointer.
    always_comb begin
        sp_wr_en   = i_cmd.create_wr || i_cmd.switch_wr;
        sp_wr_addr = i_cmd.create_wr ? new_slot : r_cur;
        sp_wr_data = i_cmd.create_wr ? r_stack_top : r_saved_sp;
    end

    rrts_ram #(
        .WIDTH (CTL_W),
        .DEPTH (TASK_SLOTS)
    ) u_ctl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ctl_wr_en),
        .i_wr_addr (ctl_wr_addr),
        .i_wr_data (ctl_wr_data),
        .i_rd_en   (ctl_rd_en),
        .i_rd_addr (ctl_rd_addr),
        .o_rd_data (ctl_q)
    );

    rrts_ram #(
        .WIDTH (32),
        .DEPTH (TASK_SLOTS)
    ) u_sp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sp_wr_en),
        .i_wr_addr (sp_wr_addr),
        .i_wr_data (sp_wr_data),
        .i_rd_en   (i_cmd.sp_rd_p),
        .i_rd_addr (r_p),
        .o_rd_data (sp_q)
    );

    rrts_ram #(
        .WIDTH (32),
        .DEPTH (TASK_SLOTS)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.create_wr),
        .i_wr_addr (new_slot),
        .i_wr_data (r_entry_addr),
        .i_rd_en   (i_cmd.sp_rd_p),
        .i_rd_addr (r_p),
        .o_rd_data (entry_q)
    );

    // Request capture; the stack top is formed here, wrapping at 32 bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func       <= i_func;
            r_entry_addr <= i_entry_addr;
            r_stack_top  <= i_stack_base + {16'd0, i_stack_bytes} - 32'd1;
            r_saved_sp   <= i_saved_sp;
            r_sem_index  <= i_sem_index;
            r_init_count <= i_init_count;
        end
    end

    // Valid bits of the control RAM, read alongside its data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_v <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            if (ctl_wr_en) begin
                r_ctl_v[ctl_wr_addr] <= 1'b1;
            end
            if (ctl_rd_en) begin
                r_rd_v <= r_ctl_v[ctl_rd_addr];
            end
        end
    end

    // Current slot and table fill.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_used <= USED_W'(1);
        end else begin
            if (i_cmd.create_link) begin
                r_used <= r_used + USED_W'(1);
            end
            if (i_cmd.switch_fin) begin
                r_cur <= r_p;
            end
        end
    end

    // Semaphore counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SEM_COUNT; k++) begin
                r_sem[k] <= 16'sd0;
            end
        end else if (i_cmd.sem_wr) begin
            case (r_func)
                FN_SEM_INIT:   r_sem[sem_idx] <= r_init_count;
                FN_SEM_WAIT:   r_sem[sem_idx] <= sem_dec;
                FN_SEM_SIGNAL: r_sem[sem_idx] <= sem_inc;
                default:       r_sem[sem_idx] <= sem_cur;
            endcase
        end
    end

    // Ring walk pointer, step count and the tag being looked for.
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_p    <= q_next;
            r_cnt  <= '0;
            r_want <= (r_func == FN_SWITCH) ? TAG_W'(0) : sem_tag;
        end else if (i_cmd.walk_step) begin
            r_p   <= q_next;
            r_cnt <= r_cnt + SLOT_W'(1);
        end
    end

    // Pending result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_res_task_id     <= 3'(r_cur);
            r_res_next_sp     <= '0;
            r_res_start_new   <= 1'b0;
            r_res_start_entry <= '0;
            r_res_sw_req      <= 1'b0;
            r_res_status      <= ST_OK;
        end
        if (i_cmd.res_full) begin
            r_res_task_id <= '0;
            r_res_status  <= ST_FULL;
        end
        if (i_cmd.create_wr) begin
            r_res_task_id <= 3'(new_slot);
        end
        if (i_cmd.wait_wr) begin
            r_res_sw_req <= 1'b1;
        end
        if (i_cmd.res_no_run) begin
            r_res_next_sp <= r_saved_sp;
            r_res_status  <= ST_NO_RUN;
        end
        if (i_cmd.res_no_waiter) begin
            r_res_status <= ST_NO_WAITER;
        end
        if (i_cmd.switch_fin) begin
            r_res_task_id     <= 3'(r_p);
            r_res_next_sp     <= sp_q;
            r_res_start_new   <= start_new;
            r_res_start_entry <= start_new ? entry_q : 32'd0;
        end
    end

    // Output register: one result beat, held while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_task_id     <= r_res_task_id;
            r_out_next_sp     <= r_res_next_sp;
            r_out_start_new   <= r_res_start_new;
            r_out_start_entry <= r_res_start_entry;
            r_out_sw_req      <= r_res_sw_req;
            r_out_status      <= r_res_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_task_id        = r_out_task_id;
    assign o_next_sp        = r_out_next_sp;
    assign o_start_new      = r_out_start_new;
    assign o_start_entry    = r_out_start_entry;
    assign o_switch_request = r_out_sw_req;
    assign o_status         = r_out_status;

endmodule

FILE: rtl/round_robin_task_scheduler_semaphores.sv
// ============================================================================
// round_robin_task_scheduler_semaphores: ring task scheduler with semaphores
// Creates tasks into a slot ring, switches round robin past blocked tasks
// and keeps saturating counting semaphores that block and wake tasks.
// ============================================================================
// One request at a time. Create writes the new slot and then links it into the
// ring, and a blocking wait tags the current task with its semaphore. Switch and
// a waking signal walk the ring one slot per cycle until a slot matches or every
// slot has been checked. The next request is taken once the result is in the
// output register. Reset is synchronous and leaves the idle task in slot 0 as
// the only, current task.
module round_robin_task_scheduler_semaphores
    import rrts_pkg::*;
#(
    parameter int TASK_SLOTS = 8,
    parameter int SEM_COUNT  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_func,
    input  logic [31:0]        i_entry_addr,
    input  logic [31:0]        i_stack_base,
    input  logic [15:0]        i_stack_bytes,
    input  logic [31:0]        i_saved_sp,
    input  logic [2:0]         i_sem_index,
    input  logic signed [15:0] i_init_count,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_task_id,
    output logic [31:0]        o_next_sp,
    output logic               o_start_new,
    output logic [31:0]        o_start_entry,
    output logic               o_switch_request,
    output logic [1:0]         o_status
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Request sequencer.
    rrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Task table, semaphores and result register.
    rrts_dpath #(
        .TASK_SLOTS (TASK_SLOTS),
        .SEM_COUNT  (SEM_COUNT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_func           (i_func),
        .i_entry_addr     (i_entry_addr),
        .i_stack_base     (i_stack_base),
        .i_stack_bytes    (i_stack_bytes),
        .i_saved_sp       (i_saved_sp),
        .i_sem_index      (i_sem_index),
        .i_init_count     (i_init_count),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_task_id        (o_task_id),
        .o_next_sp        (o_next_sp),
        .o_start_new      (o_start_new),
        .o_start_entry    (o_start_entry),
        .o_switch_request (o_switch_request),
        .o_status         (o_status)
    );

    // A result is loaded only when the output register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded into a busy output register");

    // An accepted beat closes the input until its result is loaded into the output register.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // The walk never steps past a matching slot.
    a_walk_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_step |-> !sts.walk_match)
        else $error("ring walk stepped past a match");

endmodule
